### rtl/sorted_priority_queue_core_defines.svh
// Assertion macros for the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Checked at every rising edge of clk outside of reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH     = 64;
  localparam int TAG_BITS  = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DELETE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                 enq;
    logic                 deq;
    logic                 del;
    logic [TAG_BITS-1:0]  new_tag;
    logic [PRIO_BITS-1:0] new_prio;
  } cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted chain: compares against the broadcast key and shifts.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_le,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  input  logic       hit_in,
  output entry_t     entry,
  output logic       le,
  output logic       hit_out,
  output logic       first
);

  entry_t entry_next;
  logic   match;

  always_comb begin
    match   = occupied && (entry.tag == ctrl.new_tag);
    le      = occupied && (entry.prio <= ctrl.new_prio);
    hit_out = hit_in | match;
    first   = match & ~hit_in;
  end

  // On enqueue, cells holding larger keys move one place back and the first of
  // them takes the new entry. On removal, cells at or behind the removed slot
  // pull from their right neighbor.
  always_comb begin
    entry_next = entry;
    if (ctrl.enq) begin
      if (!le) begin
        if (left_le) begin
          entry_next.tag  = ctrl.new_tag;
          entry_next.prio = ctrl.new_prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (ctrl.deq || (ctrl.del && hit_out)) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### rtl/sorted_priority_queue_core.sv
// Sorted priority queue: a request channel in, one response per request out.
// Requests carry operation, item_tag and item_priority; a request transfers on
// a rising edge with req_valid high and req_stall low. Operation enqueue
// inserts the pair behind every entry of smaller or equal priority, dequeue
// serves the head, delete removes the first entry from the head with a
// matching tag. Each response gives status, the served or deleted entry
// (zero otherwise) and the occupancy after the request.
// The entries live in a row of cells that all compare against the request
// key and shift toward or away from the head together, so every request is
// finished in the cycle it transfers: its response is registered at that edge,
// and one request per cycle is sustained while the response is not stalled.
// The response sits in an output register until it transfers with rsp_valid
// high and rsp_stall low. While it is stalled, req_stall is raised and no
// new request is taken.
// Reset empties the queue and drops any pending response; the contents of
// the cells are not cleared and are never read before being written.
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           operation,
  input  logic [TAG_BITS-1:0]  item_tag,
  input  logic [PRIO_BITS-1:0] item_priority,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           status,
  output logic [TAG_BITS-1:0]  out_tag,
  output logic [PRIO_BITS-1:0] out_priority,
  output logic [CNT_BITS-1:0]  occupancy
);

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                found;
  cell_ctrl_t          ctrl;
  status_t             res_status;
  entry_t              res_entry;
  entry_t              hit_entry;

  entry_t              cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_le;
  logic [DEPTH-1:0]    cell_hit;
  logic [DEPTH-1:0]    cell_first;
  logic [DEPTH-1:0]    occupied;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CNT_BITS'(DEPTH));
  assign is_empty  = (count == '0);
  assign found     = cell_hit[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_le;
    logic   hit_in;

    assign occupied[i] = (CNT_BITS'(i) < count);

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_le    = 1'b1;
      assign hit_in     = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
      assign hit_in     = cell_hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .hit_in      (hit_in),
      .entry       (cell_entry[i]),
      .le          (cell_le[i]),
      .hit_out     (cell_hit[i]),
      .first       (cell_first[i])
    );
  end

  // At most one cell flags the first match, so an OR over the row selects it.
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        hit_entry = entry_t'(hit_entry | cell_entry[i]);
      end
    end
  end

  always_comb begin
    ctrl          = '0;
    ctrl.new_tag  = item_tag;
    ctrl.new_prio = item_priority;
    res_status    = ST_DONE;
    res_entry     = '0;
    count_next    = count;
    case (op_t'(operation))
      OP_ENQUEUE: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.enq   = accept;
          count_next = count + CNT_BITS'(1);
        end
      end
      OP_DEQUEUE: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.deq   = accept;
          res_entry  = cell_entry[0];
          count_next = count - CNT_BITS'(1);
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          ctrl.del   = accept;
          res_entry  = hit_entry;
          count_next = count - CNT_BITS'(1);
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      out_tag      <= res_entry.tag;
      out_priority <= res_entry.prio;
      occupancy    <= count_next;
    end
  end

endmodule

### rtl/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to its top level.
`include "sorted_priority_queue_core_defines.svh"

module spq_checker import spq_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input logic [1:0]           status,
  input logic [TAG_BITS-1:0]  out_tag,
  input logic [CNT_BITS-1:0]  occupancy
);

  `SPQ_ASSERT_ALWAYS(a_reset_drops_rsp, rst |=> !rsp_valid, "response valid after reset")
  `SPQ_ASSERT(a_req_gives_rsp, req_valid && !req_stall |=> rsp_valid, "request without response")
  `SPQ_ASSERT(a_stalled_rsp_held, rsp_valid && rsp_stall |=> rsp_valid && $stable(occupancy), "stalled response changed")
  `SPQ_ASSERT(a_full_at_depth, rsp_valid && status == ST_FULL |-> occupancy == CNT_BITS'(DEPTH), "full status below depth")
  `SPQ_ASSERT(a_empty_at_zero, rsp_valid && status == ST_EMPTY |-> occupancy == '0 && out_tag == '0, "empty status with entries")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
